[rtl/core/sstf_pkg.sv]
// shared constants and types for the shortest-seek-first scheduler
package sstf_pkg;

   // storage sizing
   localparam int MAX_REQUESTS = 16;
   localparam int CYL_BITS     = 16;
   localparam int IDX_BITS     = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
   localparam int CNT_BITS     = $clog2(MAX_REQUESTS + 1);

   // transaction field widths
   localparam int CYL_FIELD_BITS   = 16;
   localparam int IDX_FIELD_BITS   = 4;
   localparam int LIMIT_BITS       = 16;
   localparam int TOTAL_BITS       = 20;
   localparam int REQ_DATA_BITS    = 16;
   localparam int RSP_DATA_BITS    = 56;

   // distance and seek sum widths
   localparam int DIST_BITS = (CYL_BITS > LIMIT_BITS) ? CYL_BITS : LIMIT_BITS;
   localparam int SUM_BITS  = ((DIST_BITS > TOTAL_BITS) ? DIST_BITS : TOTAL_BITS) + 1;

   // picks per run
   localparam int RESULT_CAP = 16;
   localparam int PICK_BITS  = $clog2(RESULT_CAP + 1);

   localparam logic [TOTAL_BITS-1:0] TOTAL_MAX        = '1;
   localparam logic [LIMIT_BITS-1:0] SEEK_LIMIT_RESET = 16'd9999;

   // register map (index taken from paddr[2])
   localparam int  CSR_ADDR_BITS  = 3;
   localparam logic REG_SEEK_LIMIT = 1'b0;

   // request kinds
   localparam logic ACT_LOAD = 1'b0;
   localparam logic ACT_RUN  = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   // search wavefront passed from cell to cell
   typedef struct packed {
      logic                 valid;
      logic                 found;
      logic [CYL_BITS-1:0]  head;
      logic [DIST_BITS-1:0] best_dist;
      logic [IDX_BITS-1:0]  best_idx;
      logic [CYL_BITS-1:0]  best_cyl;
   } wave_type;

   // broadcast controls from the sequencer to every cell
   typedef struct packed {
      logic                load_en;
      logic                mark_en;
      logic                clear;
      logic [IDX_BITS-1:0] idx;
      logic [CYL_BITS-1:0] cyl;
   } ctl_type;

   // one result transaction
   typedef struct packed {
      logic [TOTAL_BITS-1:0]     total;
      logic [CYL_FIELD_BITS-1:0] move;
      logic [CYL_FIELD_BITS-1:0] cyl;
      logic [IDX_FIELD_BITS-1:0] idx;
      logic                      served;
      logic                      last;
   } rsp_type;

endpackage

[rtl/core/sstf_cell.sv]
// one request slot: holds a cylinder and its served mark, updates the passing search
module sstf_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sstf_pkg::IDX_BITS-1:0] cell_idx,
   input  logic [sstf_pkg::CNT_BITS-1:0] count,
   input  sstf_pkg::ctl_type             ctl,
   input  sstf_pkg::wave_type            wave_in,
   output sstf_pkg::wave_type            wave_out
);
   import sstf_pkg::*;

   logic [CYL_BITS-1:0]  cyl_ff;
   logic                 served_ff;
   logic                 served_in;
   wave_type             wave_ff;
   wave_type             wave_in_nxt;
   logic [CYL_BITS-1:0]  span;
   logic                 in_range;
   logic                 hit;
   logic                 sel;

   assign sel      = (ctl.idx == cell_idx);
   assign in_range = (CNT_BITS'(cell_idx) < count);

   // compare this slot against the best so far
   always_comb begin
      span = (wave_in.head > cyl_ff) ? (wave_in.head - cyl_ff) : (cyl_ff - wave_in.head);
      hit  = wave_in.valid && in_range && !served_ff &&
             (DIST_BITS'(span) < wave_in.best_dist);
      wave_in_nxt = wave_in;
      if (hit) begin
         wave_in_nxt.found     = 1'b1;
         wave_in_nxt.best_dist = DIST_BITS'(span);
         wave_in_nxt.best_idx  = cell_idx;
         wave_in_nxt.best_cyl  = cyl_ff;
      end
   end

   // served mark next value
   always_comb begin
      served_in = served_ff;
      if (ctl.clear) begin
         served_in = 1'b0;
      end else if (ctl.load_en && sel) begin
         served_in = 1'b0;
      end else if (ctl.mark_en && sel) begin
         served_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         served_ff     <= 1'b0;
         wave_ff.valid <= 1'b0;
      end else begin
         served_ff     <= served_in;
         wave_ff.valid <= wave_in_nxt.valid;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (ctl.load_en && sel) begin
         cyl_ff <= ctl.cyl;
      end
      wave_ff.found     <= wave_in_nxt.found;
      wave_ff.head      <= wave_in_nxt.head;
      wave_ff.best_dist <= wave_in_nxt.best_dist;
      wave_ff.best_idx  <= wave_in_nxt.best_idx;
      wave_ff.best_cyl  <= wave_in_nxt.best_cyl;
   end

   assign wave_out = wave_ff;

endmodule

[rtl/core/shortest_seek_first_scheduler.sv]
// shortest-seek-first scheduler: request cell chain plus run sequencer
//
//   channel   direction   tdata                     tuser     tlast
//   req_      in          cylinder                  action    -
//   rsp_      out         idx,cyl,move,total        served    last
//   csr_      in/out      apb, seek_limit at 0x0    -         -
//
// each search launches a front from a register, sends it down the chain of
// MAX_REQUESTS cells, one cell per cycle, and then decides; a run does one
// search per pick and one more that finds nothing (none after the sixteenth
// pick), and ends with a decide step that sends the last result.
// synchronous reset clears the count, the served marks and seek_limit to 9999.
// a stalled result port holds the sequencer in its decide step; loads and new
// runs are taken only while no run is in progress.
module shortest_seek_first_scheduler (
   input  logic                               clock,
   input  logic                               reset,
   // request stream
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [sstf_pkg::REQ_DATA_BITS-1:0] req_tdata,   // [15:0] cylinder
   input  logic                               req_tuser,   // [0] action
   // result stream
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [3:0] pick_index, [19:4] pick_cylinder, [35:20] move_distance, [55:36] seek_total
   output logic [sstf_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   output logic                               rsp_tuser,   // [0] served
   output logic                               rsp_tlast,
   // configuration
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [sstf_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [31:0]                        csr_pwdata,
   output logic [31:0]                        csr_prdata,
   output logic                               csr_pready
);
   import sstf_pkg::*;

   state_type             state_ff, state_in;
   logic [CNT_BITS-1:0]   count_ff, count_in;
   logic [LIMIT_BITS-1:0] limit_ff;
   logic [PICK_BITS-1:0]  picks_ff, picks_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   wave_type              launch_ff, launch_in;
   logic                  scan_found_ff, scan_found_in;
   logic [IDX_BITS-1:0]   scan_idx_ff, scan_idx_in;
   logic [CYL_BITS-1:0]   scan_cyl_ff, scan_cyl_in;
   logic [DIST_BITS-1:0]  scan_dist_ff, scan_dist_in;
   logic                  pend_valid_ff, pend_valid_in;
   rsp_type               pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   ctl_type               ctl;
   wave_type              chain [MAX_REQUESTS+1];
   logic                  req_accept;
   logic                  out_free;
   logic                  csr_wr;
   logic [CYL_BITS-1:0]   req_cyl;
   logic [SUM_BITS-1:0]   sum;
   logic [TOTAL_BITS-1:0] total_new;

   // cell chain
   assign chain[0] = launch_ff;

   for (genvar i = 0; i < MAX_REQUESTS; i++) begin : g_cell
      sstf_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (IDX_BITS'(i)),
         .count    (count_ff),
         .ctl      (ctl),
         .wave_in  (chain[i]),
         .wave_out (chain[i+1])
      );
   end

   // configuration port
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_SEEK_LIMIT);
   assign csr_prdata = (csr_paddr[2] == REG_SEEK_LIMIT) ? 32'(limit_ff) : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= SEEK_LIMIT_RESET;
      end else if (csr_wr) begin
         limit_ff <= csr_pwdata[LIMIT_BITS-1:0];
      end
   end

   // handshakes
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign req_cyl    = CYL_BITS'(req_tdata);

   // saturating seek sum
   always_comb begin
      sum       = SUM_BITS'(total_ff) + SUM_BITS'(scan_dist_ff);
      total_new = (sum > SUM_BITS'(TOTAL_MAX)) ? TOTAL_MAX : sum[TOTAL_BITS-1:0];
   end

   // sequencer: next state and outputs
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      picks_in      = picks_ff;
      total_in      = total_ff;
      launch_in     = launch_ff;
      launch_in.valid = 1'b0;
      scan_found_in = scan_found_ff;
      scan_idx_in   = scan_idx_ff;
      scan_cyl_in   = scan_cyl_ff;
      scan_dist_in  = scan_dist_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_in        = rsp_ff;
      ctl           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               if (req_tuser == ACT_LOAD) begin
                  // append a request while there is room
                  if (count_ff < CNT_BITS'(MAX_REQUESTS)) begin
                     ctl.load_en = 1'b1;
                     ctl.idx     = count_ff[IDX_BITS-1:0];
                     ctl.cyl     = req_cyl;
                     count_in    = count_ff + 1'b1;
                  end
               end else begin
                  // start a run from the given head
                  launch_in.valid     = 1'b1;
                  launch_in.found     = 1'b0;
                  launch_in.head      = req_cyl;
                  launch_in.best_dist = DIST_BITS'(limit_ff);
                  total_in            = '0;
                  picks_in            = '0;
                  pend_valid_in       = 1'b0;
                  state_in            = ST_SCAN;
               end
            end
         end

         ST_SCAN: begin
            // capture the front as it leaves the last cell
            if (chain[MAX_REQUESTS].valid) begin
               scan_found_in = chain[MAX_REQUESTS].found;
               scan_idx_in   = chain[MAX_REQUESTS].best_idx;
               scan_cyl_in   = chain[MAX_REQUESTS].best_cyl;
               scan_dist_in  = chain[MAX_REQUESTS].best_dist;
               state_in      = ST_DECIDE;
            end
         end

         ST_DECIDE: begin
            if (out_free) begin
               if (scan_found_ff) begin
                  // release the held pick, hold the new one until the next search
                  if (pend_valid_ff) begin
                     rsp_valid_in = 1'b1;
                     rsp_in       = pend_ff;
                     rsp_in.last  = 1'b0;
                  end
                  pend_valid_in  = 1'b1;
                  pend_in.idx    = IDX_FIELD_BITS'(scan_idx_ff);
                  pend_in.cyl    = CYL_FIELD_BITS'(scan_cyl_ff);
                  pend_in.move   = CYL_FIELD_BITS'(scan_dist_ff);
                  pend_in.total  = total_new;
                  pend_in.served = 1'b1;
                  pend_in.last   = 1'b0;
                  total_in       = total_new;
                  picks_in       = picks_ff + 1'b1;
                  ctl.mark_en    = 1'b1;
                  ctl.idx        = scan_idx_ff;
                  if (picks_ff == PICK_BITS'(RESULT_CAP - 1)) begin
                     // pick cap reached: finish on the next decide
                     scan_found_in = 1'b0;
                  end else begin
                     launch_in.valid     = 1'b1;
                     launch_in.found     = 1'b0;
                     launch_in.head      = scan_cyl_ff;
                     launch_in.best_dist = DIST_BITS'(limit_ff);
                     state_in            = ST_SCAN;
                  end
               end else begin
                  // end of run: final pick or an empty result
                  rsp_valid_in = 1'b1;
                  if (pend_valid_ff) begin
                     rsp_in      = pend_ff;
                     rsp_in.last = 1'b1;
                  end else begin
                     rsp_in      = '0;
                     rsp_in.last = 1'b1;
                  end
                  pend_valid_in = 1'b0;
                  ctl.clear     = 1'b1;
                  count_in      = '0;
                  state_in      = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state register and control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         count_ff        <= '0;
         launch_ff.valid <= 1'b0;
         pend_valid_ff   <= 1'b0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         launch_ff.valid <= launch_in.valid;
         pend_valid_ff   <= pend_valid_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      picks_ff            <= picks_in;
      total_ff            <= total_in;
      launch_ff.found     <= launch_in.found;
      launch_ff.head      <= launch_in.head;
      launch_ff.best_dist <= launch_in.best_dist;
      launch_ff.best_idx  <= launch_in.best_idx;
      launch_ff.best_cyl  <= launch_in.best_cyl;
      scan_found_ff       <= scan_found_in;
      scan_idx_ff         <= scan_idx_in;
      scan_cyl_ff         <= scan_cyl_in;
      scan_dist_ff        <= scan_dist_in;
      pend_ff             <= pend_in;
      rsp_ff              <= rsp_in;
   end

   // result port
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ff.total, rsp_ff.move, rsp_ff.cyl, rsp_ff.idx};
   assign rsp_tuser  = rsp_ff.served;
   assign rsp_tlast  = rsp_ff.last;

endmodule
